FILE: rtl/mhpq_pkg.sv
package mhpq_pkg;

    localparam int HEAP_DEPTH_DEF   = 64;
    localparam int PAYLOAD_BITS_DEF = 16;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic rd_root;
        logic ld_root;
        logic rd_up;
        logic up_move;
        logic rd_kids;
        logic dn_move;
        logic place;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic cnt_zero;
        logic pos_zero;
        logic up_win;
        logic l_valid;
        logic dn_win;
        logic out_busy;
    } t_sts;

endpackage

FILE: rtl/mhpq_ram.sv
module mhpq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

FILE: rtl/mhpq_dpath.sv
module mhpq_dpath #(
    parameter int HEAP_DEPTH   = 64,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mhpq_pkg::t_cmd    i_cmd,
    output mhpq_pkg::t_sts    o_sts,
    input  logic              i_mode,
    input  logic [31:0]       i_in_key,
    input  logic [31:0]       i_in_secondary_key,
    input  logic [15:0]       i_in_payload,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [31:0]       o_out_key,
    output logic [31:0]       o_out_secondary_key,
    output logic [15:0]       o_out_payload,
    output logic [6:0]        o_entry_total
);

    import mhpq_pkg::*;

    localparam int AW  = $clog2(HEAP_DEPTH);
    localparam int CW  = $clog2(HEAP_DEPTH + 1);
    localparam int XW  = AW + 2;
    localparam int CXW = CW + 7;
    localparam int EW  = 64 + PAYLOAD_BITS;

    function automatic logic f_beats(input logic [31:0] ka, input logic [31:0] sa,
                                     input logic [31:0] kb, input logic [31:0] sb);
        return (ka != kb) ? (ka > kb) : (sa < sb);
    endfunction

    logic [CW-1:0]           r_count;
    logic [AW-1:0]           r_pos;
    logic [31:0]             r_elem_key;
    logic [31:0]             r_elem_sec;
    logic [PAYLOAD_BITS-1:0] r_elem_pay;
    logic [1:0]              r_status;
    logic [31:0]             r_res_key;
    logic [31:0]             r_res_sec;
    logic [PAYLOAD_BITS-1:0] r_res_pay;

    logic [EW-1:0]  rdata_a;
    logic [EW-1:0]  rdata_b;
    logic [EW-1:0]  elem_word;
    logic [EW-1:0]  wdata;
    logic           we;
    logic [AW-1:0]  raddr_a;
    logic [AW-1:0]  raddr_b;
    logic [31:0]    in_pay32;
    logic [31:0]    res_pay32;
    logic [CXW-1:0] cnt_ext;
    logic [CW-1:0]  cnt_m1;
    logic [AW-1:0]  pos_m1;
    logic [AW-1:0]  parent;
    logic [XW-1:0]  pos_x;
    logic [XW-1:0]  l_x;
    logic [XW-1:0]  r_x;
    logic [XW-1:0]  cnt_x;
    logic           l_valid;
    logic           r_valid;
    logic [31:0]    a_key;
    logic [31:0]    a_sec;
    logic [31:0]    b_key;
    logic [31:0]    b_sec;
    logic           up_win;
    logic           take_l;
    logic           take_r;
    logic [31:0]    best_key;
    logic [31:0]    best_sec;
    logic [EW-1:0]  child_word;
    logic [AW-1:0]  child_idx;

    assign in_pay32  = 32'(i_in_payload);
    assign res_pay32 = 32'(r_res_pay);
    assign cnt_ext   = CXW'(r_count);
    assign elem_word = {r_elem_key, r_elem_sec, r_elem_pay};

    assign cnt_m1 = r_count - CW'(1);
    assign pos_m1 = r_pos - AW'(1);
    assign parent = pos_m1 >> 1;
    assign pos_x  = XW'(r_pos);
    assign l_x    = (pos_x << 1) + XW'(1);
    assign r_x    = l_x + XW'(1);
    assign cnt_x  = XW'(r_count);
    assign l_valid = l_x < cnt_x;
    assign r_valid = r_x < cnt_x;

    assign a_key = rdata_a[EW-1 -: 32];
    assign a_sec = rdata_a[EW-33 -: 32];
    assign b_key = rdata_b[EW-1 -: 32];
    assign b_sec = rdata_b[EW-33 -: 32];

    assign up_win   = f_beats(r_elem_key, r_elem_sec, a_key, a_sec);
    assign take_l   = f_beats(a_key, a_sec, r_elem_key, r_elem_sec);
    assign best_key = take_l ? a_key : r_elem_key;
    assign best_sec = take_l ? a_sec : r_elem_sec;
    assign take_r   = r_valid && f_beats(b_key, b_sec, best_key, best_sec);
    assign child_word = take_r ? rdata_b : rdata_a;
    assign child_idx  = take_r ? r_x[AW-1:0] : l_x[AW-1:0];

    always_comb begin
        raddr_a = r_pos;
        raddr_b = r_pos;
        if (i_cmd.rd_root) begin
            raddr_a = '0;
            raddr_b = cnt_m1[AW-1:0];
        end else if (i_cmd.rd_up) begin
            raddr_a = parent;
        end else if (i_cmd.rd_kids) begin
            raddr_a = l_x[AW-1:0];
            raddr_b = r_x[AW-1:0];
        end
    end

    assign we    = i_cmd.up_move | i_cmd.dn_move | i_cmd.place;
    assign wdata = i_cmd.up_move ? rdata_a : (i_cmd.dn_move ? child_word : elem_word);

    mhpq_ram #(
        .WIDTH(EW),
        .DEPTH(HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_pos),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    always_comb begin
        o_sts.full     = r_count == CW'(HEAP_DEPTH);
        o_sts.empty    = r_count == '0;
        o_sts.cnt_zero = r_count == '0;
        o_sts.pos_zero = r_pos == '0;
        o_sts.up_win   = up_win;
        o_sts.l_valid  = l_valid;
        o_sts.dn_win   = take_l | take_r;
        o_sts.out_busy = o_valid & ~i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.capture) begin
            if (!i_mode && r_count != CW'(HEAP_DEPTH)) begin
                r_count <= r_count + CW'(1);
            end else if (i_mode && r_count != '0) begin
                r_count <= cnt_m1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_elem_key <= i_in_key;
            r_elem_sec <= i_in_secondary_key;
            r_elem_pay <= in_pay32[PAYLOAD_BITS-1:0];
            r_pos      <= r_count[AW-1:0];
            r_res_key  <= '0;
            r_res_sec  <= '0;
            r_res_pay  <= '0;
            if (!i_mode) begin
                r_status <= (r_count == CW'(HEAP_DEPTH)) ? ST_FULL : ST_OK;
            end else begin
                r_status <= (r_count == '0) ? ST_EMPTY : ST_OK;
            end
        end else if (i_cmd.ld_root) begin
            r_res_key  <= a_key;
            r_res_sec  <= a_sec;
            r_res_pay  <= rdata_a[PAYLOAD_BITS-1:0];
            r_elem_key <= b_key;
            r_elem_sec <= b_sec;
            r_elem_pay <= rdata_b[PAYLOAD_BITS-1:0];
            r_pos      <= '0;
        end else if (i_cmd.up_move) begin
            r_pos <= parent;
        end else if (i_cmd.dn_move) begin
            r_pos <= child_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_status            <= r_status;
            o_out_key           <= r_res_key;
            o_out_secondary_key <= r_res_sec;
            o_out_payload       <= res_pay32[15:0];
            o_entry_total       <= cnt_ext[6:0];
        end
    end

endmodule

FILE: rtl/mhpq_ctrl.sv
module mhpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_mode,
    output logic           o_ready,
    input  mhpq_pkg::t_sts i_sts,
    output mhpq_pkg::t_cmd o_cmd
);

    import mhpq_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP     = 8'b0000_0010,
        S_UP_CMP = 8'b0000_0100,
        S_EX_LD  = 8'b0000_1000,
        S_DN_RD  = 8'b0001_0000,
        S_DN_CMP = 8'b0010_0000,
        S_FIN    = 8'b0100_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_mode) begin
                        n_state = i_sts.full ? S_FIN : S_UP;
                    end else if (i_sts.empty) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.rd_root = 1'b1;
                        n_state = S_EX_LD;
                    end
                end
            end
            S_UP: begin
                if (i_sts.pos_zero) begin
                    o_cmd.place = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_up = 1'b1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_sts.up_win) begin
                    o_cmd.up_move = 1'b1;
                    n_state = S_UP;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_EX_LD: begin
                o_cmd.ld_root = 1'b1;
                n_state = i_sts.cnt_zero ? S_FIN : S_DN_RD;
            end
            S_DN_RD: begin
                if (!i_sts.l_valid) begin
                    o_cmd.place = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.rd_kids = 1'b1;
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (i_sts.dn_win) begin
                    o_cmd.dn_move = 1'b1;
                    n_state = S_DN_RD;
                end else begin
                    o_cmd.place = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/max_heap_priority_queue.sv
// Channel  Handshake          Fields
// -------  -----------------  -----------------------------------------------------------
// input    i_valid / o_ready  i_mode, i_in_key, i_in_secondary_key, i_in_payload
// output   o_valid / i_ready  o_status, o_out_key, o_out_secondary_key, o_out_payload,
//                             o_entry_total
//
// One item is worked on at a time; o_ready is high only while the controller is idle.
// An insert reads and compares the parent once per level climbed, then writes the new entry;
// an extract reads the root and the last entry, then reads and compares children per level.
// A refused insert or an empty extract goes straight to the finish state with its status.
// Reset is synchronous and empties the heap at once; no clearing pass is needed.
// The result waits in an output register; while it stalls, the next item waits at its end.
module max_heap_priority_queue #(
    parameter int HEAP_DEPTH   = mhpq_pkg::HEAP_DEPTH_DEF,
    parameter int PAYLOAD_BITS = mhpq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [31:0] i_in_key,
    input  logic [31:0] i_in_secondary_key,
    input  logic [15:0] i_in_payload,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_key,
    output logic [31:0] o_out_secondary_key,
    output logic [15:0] o_out_payload,
    output logic [6:0]  o_entry_total
);

    import mhpq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mhpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mhpq_dpath #(
        .HEAP_DEPTH   (HEAP_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_mode              (i_mode),
        .i_in_key            (i_in_key),
        .i_in_secondary_key  (i_in_secondary_key),
        .i_in_payload        (i_in_payload),
        .i_ready             (i_ready),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_out_key           (o_out_key),
        .o_out_secondary_key (o_out_secondary_key),
        .o_out_payload       (o_out_payload),
        .o_entry_total       (o_entry_total)
    );

endmodule
